### sv/well_vertical_depth_tracker_defines.svh
// Assertion macros for the well vertical depth tracker checker.
// Needs signals clk and arst_n in the scope of each use.
`ifndef WELL_VERTICAL_DEPTH_TRACKER_DEFINES_SVH
`define WELL_VERTICAL_DEPTH_TRACKER_DEFINES_SVH

// same-cycle implication, reset masks the check
`define WVDT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks the check
`define WVDT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/wvdt_pkg.sv
// Shared widths, register codes and controller/datapath interface types
// for the well vertical depth tracker. No dependencies.
package wvdt_pkg;

	localparam int DATA_W     = 32;
	localparam int COORD_BITS = 32;
	localparam int DIFF_BITS  = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam int MAG_W      = DIFF_BITS - 1;       // saturated |difference|
	localparam int SQ_W       = 2 * MAG_W;           // one square
	localparam int H2_W       = SQ_W + 1;            // sum of two squares
	localparam int ROOT_W     = (H2_W + 1) / 2;      // floor sqrt width
	localparam int RADX_W     = 2 * ROOT_W;          // radicand shift register
	localparam int REM_W      = ROOT_W + 2;          // partial remainder
	localparam int CNT_W      = $clog2(ROOT_W);
	localparam int IN_TDATA_W = 3 * DATA_W;
	localparam int ADDR_W     = 3;

	localparam logic signed [DATA_W-1:0] NODATA_RESET = -32'sd255744;
	localparam logic signed [DATA_W-1:0] KELLY_RESET  = 32'sd0;

	typedef enum logic {
		REG_NODATA = 1'b0,
		REG_KELLY  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		MUL_X = 2'd0,
		MUL_Y = 2'd1,
		MUL_Z = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic     capture;     // latch input word
		logic     take_nodata; // result = no-data code
		logic     take_first;  // result = depth - offset, store point
		logic     take_diff;   // register saturated difference magnitudes
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     sum_en;      // dx^2 + dy^2
		logic     rad_en;      // |dz^2 - h2|, clear root unit
		logic     root_step;   // one result bit
		logic     acc;         // saturating add, store point
		logic     emit;        // load output register
	} ctrl_cmd_t;

	typedef struct packed {
		logic nodata_hit;
		logic seen_first;
		logic root_last;
		logic out_busy;
	} dp_status_t;

endpackage

### sv/wvdt_ctrl.sv
// Sequencing controller for the well vertical depth tracker.
// Depends on wvdt_pkg; drives wvdt_dp through ctrl_cmd_t.
module wvdt_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  wvdt_pkg::dp_status_t   status,
	output wvdt_pkg::ctrl_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SQ_X,
		ST_SQ_Y,
		ST_SQ_Z,
		ST_SUM,
		ST_RAD,
		ST_ROOT,
		ST_ACC,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cmd.mul_sel = wvdt_pkg::MUL_X;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.nodata_hit) begin
					cmd.take_nodata = 1'b1;
					state_d         = ST_EMIT;
				end else if (!status.seen_first) begin
					cmd.take_first = 1'b1;
					state_d        = ST_EMIT;
				end else begin
					cmd.take_diff = 1'b1;
					state_d       = ST_SQ_X;
				end
			end
			ST_SQ_X: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = wvdt_pkg::MUL_X;
				state_d     = ST_SQ_Y;
			end
			ST_SQ_Y: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = wvdt_pkg::MUL_Y;
				state_d     = ST_SQ_Z;
			end
			ST_SQ_Z: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = wvdt_pkg::MUL_Z;
				state_d     = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_en = 1'b1;
				state_d    = ST_RAD;
			end
			ST_RAD: begin
				cmd.rad_en = 1'b1;
				state_d    = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (status.root_last) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!status.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### sv/wvdt_dp.sv
// Datapath of the well vertical depth tracker: survey point state, shared
// squarer, bit-serial square root and output register. Depends on wvdt_pkg.
module wvdt_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  wvdt_pkg::ctrl_cmd_t                    cmd,
	output wvdt_pkg::dp_status_t                   status,
	input  logic [wvdt_pkg::IN_TDATA_W-1:0]        s_tdata,
	input  logic                                   s_tlast,
	input  logic signed [wvdt_pkg::DATA_W-1:0]     nodata_code,
	input  logic signed [wvdt_pkg::DATA_W-1:0]     kelly_offset,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [wvdt_pkg::DATA_W-1:0]            m_tdata,
	output logic                                   m_tlast
);

	localparam int DW = wvdt_pkg::DATA_W;
	localparam int MW = wvdt_pkg::MAG_W;
	localparam int SW = wvdt_pkg::SQ_W;
	localparam int HW = wvdt_pkg::H2_W;
	localparam int RW = wvdt_pkg::ROOT_W;
	localparam int XW = wvdt_pkg::RADX_W;
	localparam int EW = wvdt_pkg::REM_W;
	localparam int CW = wvdt_pkg::CNT_W;

	// |a - b|, clipped to the largest magnitude the squarer takes
	function automatic logic [MW-1:0] diff_mag(input logic [DW-1:0] a, input logic [DW-1:0] b);
		logic [DW:0] d;
		logic [DW:0] m;
		d = {a[DW-1], a} - {b[DW-1], b};
		m = d[DW] ? (~d + (DW+1)'(1)) : d;
		if (|m[DW:MW]) begin
			return {MW{1'b1}};
		end
		return m[MW-1:0];
	endfunction

	// clip a two-bit-extended sum to the signed data range
	function automatic logic [DW-1:0] sat_data(input logic [DW+1:0] v);
		if (v[DW+1:DW-1] == 3'b000 || v[DW+1:DW-1] == 3'b111) begin
			return v[DW-1:0];
		end
		return v[DW+1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
	endfunction

	// captured sample
	logic [DW-1:0] east_q, north_q, depth_q;
	logic          last_q;

	// stored survey point
	logic          seen_first_q;
	logic [DW-1:0] prev_east_q, prev_north_q, prev_depth_q, prev_vert_q;

	logic [MW-1:0] mag_x_q, mag_y_q, mag_z_q;
	logic [SW-1:0] sq_x_q, sq_y_q, sq_z_q;
	logic [HW-1:0] h2_q;
	logic [XW-1:0] rad_q;
	logic [EW-1:0] rem_q;
	logic [RW-1:0] root_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] result_q;

	logic [MW-1:0] mul_a;
	logic [SW-1:0] prod;
	logic [HW-1:0] sqz_ext;
	logic [HW-1:0] rad_diff;
	logic [EW-1:0] rem_sh;
	logic [EW-1:0] trial;
	logic          trial_ok;
	logic [DW-1:0] first_val;
	logic [DW-1:0] acc_val;
	logic          out_valid_q;

	always_comb begin
		case (cmd.mul_sel)
			wvdt_pkg::MUL_X: mul_a = mag_x_q;
			wvdt_pkg::MUL_Y: mul_a = mag_y_q;
			wvdt_pkg::MUL_Z: mul_a = mag_z_q;
			default:         mul_a = '0;
		endcase
	end

	assign prod     = {{MW{1'b0}}, mul_a} * {{MW{1'b0}}, mul_a};
	assign sqz_ext  = {1'b0, sq_z_q};
	assign rad_diff = (sqz_ext >= h2_q) ? (sqz_ext - h2_q) : (h2_q - sqz_ext);

	// restoring square root, two radicand bits per step
	assign rem_sh   = {rem_q[EW-3:0], rad_q[XW-1 -: 2]};
	assign trial    = {root_q, 2'b01};
	assign trial_ok = (rem_sh >= trial);

	assign first_val = sat_data({{2{depth_q[DW-1]}}, depth_q}
		- {{2{kelly_offset[DW-1]}}, kelly_offset});
	assign acc_val   = sat_data({{2{prev_vert_q[DW-1]}}, prev_vert_q}
		+ {{(DW+2-RW){1'b0}}, root_q});

	assign status.nodata_hit = (depth_q == nodata_code);
	assign status.seen_first = seen_first_q;
	assign status.root_last  = (cnt_q == CW'(RW - 1));
	assign status.out_busy   = out_valid_q && !m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_first_q <= 1'b0;
			prev_east_q  <= '0;
			prev_north_q <= '0;
			prev_depth_q <= '0;
			prev_vert_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.take_first || cmd.acc) begin
				seen_first_q <= 1'b1;
				prev_east_q  <= east_q;
				prev_north_q <= north_q;
				prev_depth_q <= depth_q;
				prev_vert_q  <= cmd.acc ? acc_val : first_val;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			east_q  <= s_tdata[DW-1:0];
			north_q <= s_tdata[2*DW-1:DW];
			depth_q <= s_tdata[3*DW-1:2*DW];
			last_q  <= s_tlast;
		end
		if (cmd.take_diff) begin
			mag_x_q <= diff_mag(east_q, prev_east_q);
			mag_y_q <= diff_mag(north_q, prev_north_q);
			mag_z_q <= diff_mag(depth_q, prev_depth_q);
		end
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				wvdt_pkg::MUL_X: sq_x_q <= prod;
				wvdt_pkg::MUL_Y: sq_y_q <= prod;
				wvdt_pkg::MUL_Z: sq_z_q <= prod;
				default: ;
			endcase
		end
		if (cmd.sum_en) begin
			h2_q <= {1'b0, sq_x_q} + {1'b0, sq_y_q};
		end
		if (cmd.rad_en) begin
			rad_q  <= {{(XW-HW){1'b0}}, rad_diff};
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.root_step) begin
			rad_q  <= {rad_q[XW-3:0], 2'b00};
			rem_q  <= trial_ok ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[RW-2:0], trial_ok};
			cnt_q  <= cnt_q + CW'(1);
		end
		if (cmd.take_nodata) begin
			result_q <= nodata_code;
		end else if (cmd.take_first) begin
			result_q <= first_val;
		end else if (cmd.acc) begin
			result_q <= acc_val;
		end
		if (cmd.emit) begin
			m_tdata <= result_q;
			m_tlast <= last_q;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

### sv/well_vertical_depth_tracker.sv
// Well vertical depth tracker, top level: configuration registers, controller
// and datapath. Depends on wvdt_pkg, wvdt_ctrl and wvdt_dp.
//
// Usage:
//   s_* stream: one survey sample per word (east, north, measured depth),
//     s_tlast marks the final sample of the survey and comes back on m_tlast.
//   m_* stream: one word per sample, the vertical depth or the no-data code.
//   APB port: register 0 at 0x0 is the no-data code, register 1 at 0x4 the
//     kelly-bushing offset; write only while the block is idle.
// Sequence:
//   no-data and first samples: the result is set in CHECK and loaded into
//     the output register in EMIT; the next sample is taken back in IDLE.
//   other samples: difference magnitudes are registered in CHECK, then
//     three squares on one shared 31x31 multiplier, the radicand, then a
//     square root unit that yields one result bit per cycle, then the sum.
// Only one sample is in flight; s_tready is high while the controller idles.
// The output register holds its word while m_tready is low and the next
//   sample is still accepted and computed; its result waits for the register.
// Reset clears the stored survey point, the first-sample flag and the output
//   valid bit, and loads the register reset values (no-data -999.0 m).
module well_vertical_depth_tracker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// stream in
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [wvdt_pkg::IN_TDATA_W-1:0]        s_tdata,  // east, north, measured_depth
	input  logic                                   s_tlast,  // last_row
	// stream out
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [wvdt_pkg::DATA_W-1:0]            m_tdata,  // vertical_depth
	output logic                                   m_tlast,  // last_out
	// configuration
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [wvdt_pkg::ADDR_W-1:0]            paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready
);

	logic signed [wvdt_pkg::DATA_W-1:0] nodata_q;
	logic signed [wvdt_pkg::DATA_W-1:0] kelly_q;
	wvdt_pkg::reg_idx_t                 reg_idx;
	wvdt_pkg::ctrl_cmd_t                cmd;
	wvdt_pkg::dp_status_t               status;

	assign pready  = 1'b1;
	// word-aligned registers: bit 2 picks the register
	assign reg_idx = wvdt_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodata_q <= wvdt_pkg::NODATA_RESET;
			kelly_q  <= wvdt_pkg::KELLY_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				wvdt_pkg::REG_NODATA: nodata_q <= pwdata;
				wvdt_pkg::REG_KELLY:  kelly_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			wvdt_pkg::REG_NODATA: prdata = nodata_q;
			wvdt_pkg::REG_KELLY:  prdata = kelly_q;
			default:              prdata = '0;
		endcase
	end

	wvdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	wvdt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.nodata_code  (nodata_q),
		.kelly_offset (kelly_q),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast)
	);

endmodule

### sv/wvdt_checker.sv
// Port-level checks for the well vertical depth tracker, bound to the top.
// Depends on wvdt_pkg and well_vertical_depth_tracker_defines.svh.
`include "well_vertical_depth_tracker_defines.svh"

module wvdt_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [wvdt_pkg::DATA_W-1:0]  m_tdata,
	input logic                         m_tlast,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [wvdt_pkg::ADDR_W-1:0]  paddr,
	input logic [31:0]                  pwdata,
	input logic [31:0]                  prdata
);

	// stalled output word holds
	`WVDT_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word changed under stall")

	// one sample in flight: no back-to-back acceptance
	`WVDT_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "input taken while busy")

	// a fresh result never follows acceptance at once: m_tvalid may not rise yet
	`WVDT_ASSERT_NXT(a_min_latency, s_tvalid && s_tready, !$rose(m_tvalid), "result appeared too early")

	// a register reads back what was just written to it
	`WVDT_ASSERT_IMP(a_readback, $past(arst_n) && $past(psel && penable && pwrite) && psel && !pwrite && paddr[2] == $past(paddr[2]), prdata == $past(pwdata), "register readback mismatch")

endmodule

bind well_vertical_depth_tracker wvdt_checker u_chk (.*);

### verif/testbench.sv
`timescale 1ns / 100ps
// Testbench for well_vertical_depth_tracker: survey samples in over the s_* stream, and
// depth words out over m_* are checked against a predictor kept in this file.
// Depends on wvdt_pkg and the RTL top level only.
module testbench;

	// Q23.8 helpers and word limits
	localparam int                 METRE     = 256;
	localparam logic signed [31:0] WORD_MIN  = 32'sh8000_0000;
	localparam logic signed [31:0] WORD_MAX  = 32'sh7FFF_FFFF;
	localparam longint             MAG_LIMIT = (longint'(1) << (wvdt_pkg::DIFF_BITS - 1)) - 1;
	localparam int                 WATCHDOG  = 1000;
	localparam int                 PHASE_LEN = 350;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [wvdt_pkg::IN_TDATA_W-1:0] s_tdata;   // east, north, measured_depth
	logic                            s_tlast;   // last_row
	logic                            m_tvalid;
	logic                            m_tready;
	logic [wvdt_pkg::DATA_W-1:0]     m_tdata;   // vertical_depth
	logic                            m_tlast;   // last_out
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [wvdt_pkg::ADDR_W-1:0]     paddr;
	logic [31:0]                     pwdata;
	logic [31:0]                     prdata;
	logic                            pready;

	well_vertical_depth_tracker uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// one expected output word
	typedef struct {
		logic [31:0] depth;
		logic        last;
	} depth_word_t;

	depth_word_t pending_depths[$];
	depth_word_t head_word;
	int unsigned mismatch_count = 0;

	// predictor copy of the registers and the stored survey point
	logic signed [31:0] nodata_q;
	logic signed [31:0] kelly_q;
	bit                 have_point;
	longint             pt_east, pt_north, pt_depth, pt_vertical;

	// per-phase idling of the two stream sides
	bit send_idle_on;
	bit recv_idle_on;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint clamp_word(input longint v);
		if (v > longint'(WORD_MAX))
			return longint'(WORD_MAX);
		if (v < longint'(WORD_MIN))
			return longint'(WORD_MIN);
		return v;
	endfunction

	// square of one coordinate step, magnitude capped the way the datapath caps it
	function automatic logic [63:0] sq_step(input longint a, input longint b);
		longint d;
		d = a - b;
		if (d < 0)
			d = -d;
		if (d > MAG_LIMIT)
			d = MAG_LIMIT;
		return 64'(d) * 64'(d);
	endfunction

	// floor square root, one result bit per pass from the top
	function automatic logic [63:0] floor_root(input logic [63:0] n);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int i = 31; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= n)
				root = trial;
		end
		return root;
	endfunction

	// random offset in [lo, hi] around p, kept inside the word range
	function automatic logic signed [31:0] nudge(input longint p, input int lo, input int hi);
		longint v;
		v = p + lo + longint'($urandom_range(0, hi - lo));
		return 32'(clamp_word(v));
	endfunction

	// expected depth word for one accepted sample, state updated as the block does
	task automatic track_sample(input logic signed [31:0] e, n, z, input logic last);
		longint      ev, nv, zv, res;
		logic [63:0] dz2, h2, rad;
		depth_word_t w;
		ev = longint'(e);
		nv = longint'(n);
		zv = longint'(z);
		if (z == nodata_q) begin
			res = longint'(nodata_q);
		end else if (!have_point) begin
			res = clamp_word(zv - longint'(kelly_q));
			have_point = 1'b1;
		end else begin
			dz2 = sq_step(zv, pt_depth);
			h2 = sq_step(ev, pt_east) + sq_step(nv, pt_north);
			rad = (dz2 >= h2) ? dz2 - h2 : h2 - dz2;
			res = clamp_word(pt_vertical + longint'(floor_root(rad)));
		end
		if (z != nodata_q) begin
			pt_east = ev;
			pt_north = nv;
			pt_depth = zv;
			pt_vertical = res;
		end
		w.depth = res[31:0];
		w.last = last;
		pending_depths.push_back(w);
	endtask

	// one sample word on s_*, after a random gap; valid stays up across back-to-back words
	task automatic send_sample(input logic signed [31:0] e, n, z, input logic last);
		int unsigned gap;
		gap = send_idle_on ? $urandom_range(0, 11) : 0;
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {z, n, e};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		track_sample(e, n, z, last);
	endtask

	// drop valid, let every expected word drain, then allow for the slowest sample
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_depths.size() != 0)
			@(posedge clk);
		repeat (48) @(posedge clk);
	endtask

	task automatic apb_xfer(input logic is_write, input wvdt_pkg::reg_idx_t idx,
			input logic [31:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= is_write;
		paddr <= (wvdt_pkg::ADDR_W)'({idx, 2'b00});
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_reg(input wvdt_pkg::reg_idx_t idx, input logic [31:0] want);
		logic [31:0] rd;
		apb_xfer(1'b0, idx, 32'd0, rd);
		if (rd !== want) begin
			$error("%s: expected %h, actual %h", idx.name(), want, rd);
			mismatch_count++;
		end
	endtask

	// only called while the block is idle
	task automatic cfg_write(input wvdt_pkg::reg_idx_t idx, input logic [31:0] value);
		logic [31:0] unused;
		apb_xfer(1'b1, idx, value, unused);
		case (idx)
			wvdt_pkg::REG_NODATA: nodata_q = value;
			wvdt_pkg::REG_KELLY:  kelly_q = value;
			default: ;
		endcase
		check_reg(idx, value);
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_register_reset();
		check_reg(wvdt_pkg::REG_NODATA, wvdt_pkg::NODATA_RESET);
		check_reg(wvdt_pkg::REG_KELLY, wvdt_pkg::KELLY_RESET);
	endtask

	// missing samples ahead of the first good one: echoed, no point stored
	task automatic test_nodata_before_first();
		send_sample(WORD_MAX, WORD_MIN, nodata_q, 1'b1);
		send_sample(32'sd0, 32'sd0, nodata_q, 1'b0);
	endtask

	// first good depth minus offset runs below the word range and clips
	task automatic test_first_sample_overflow();
		wait_idle();
		cfg_write(wvdt_pkg::REG_NODATA, WORD_MAX);
		cfg_write(wvdt_pkg::REG_KELLY, WORD_MAX);
		send_sample(32'sd0, 32'sd0, WORD_MIN, 1'b0);
	endtask

	// steps of 2^31 cap the difference magnitude; two capped steps cancel out
	task automatic test_saturated_steps();
		send_sample(WORD_MIN, 32'sd0, WORD_MIN, 1'b1);
		send_sample(WORD_MAX, WORD_MIN, WORD_MAX, 1'b1);   // missing sample, point kept
		send_sample(32'sd0, 32'sd0, 32'sd0, 1'b0);
	endtask

	// vertical shaft, no move, flat move, exact slant, floor of a non-square, way back up
	task automatic test_radicand_cases();
		send_sample(32'sd0, 32'sd0, 1000 * METRE, 1'b0);
		send_sample(32'sd0, 32'sd0, 1000 * METRE, 1'b1);
		send_sample(300 * METRE, 400 * METRE, 1000 * METRE, 1'b0);
		send_sample(303 * METRE, 404 * METRE, 1005 * METRE, 1'b0);
		send_sample(304 * METRE, 405 * METRE, 1008 * METRE, 1'b1);
		send_sample(250 * METRE, 350 * METRE, 900 * METRE, 1'b0);
	endtask

	// no-data code at the bottom of the range and at zero; the point survives both
	task automatic test_nodata_codes();
		wait_idle();
		cfg_write(wvdt_pkg::REG_NODATA, WORD_MIN);
		cfg_write(wvdt_pkg::REG_KELLY, WORD_MIN);
		send_sample(WORD_MAX, WORD_MIN, WORD_MIN, 1'b1);
		wait_idle();
		cfg_write(wvdt_pkg::REG_NODATA, 32'sd0);
		send_sample(32'sd123, -32'sd456, 32'sd0, 1'b0);
		send_sample(251 * METRE, 351 * METRE, 901 * METRE, 1'b1);
	endtask

	// Mostly plausible survey: short walks, long jumps whose depth step matches the
	// horizontal one (keeps the root small, so the sum has headroom), missing samples,
	// repeated points and some coarse noise.
	task automatic test_random_survey(input int phase);
		int unsigned        kind;
		logic               last;
		logic signed [31:0] e, n, z;
		logic [63:0]        h2;
		longint             h;
		wait_idle();
		case (phase % 5)
			0: cfg_write(wvdt_pkg::REG_NODATA, wvdt_pkg::NODATA_RESET);
			2: cfg_write(wvdt_pkg::REG_NODATA, 32'hFFFF_FFFF);
			default: cfg_write(wvdt_pkg::REG_NODATA, $urandom);
		endcase
		cfg_write(wvdt_pkg::REG_KELLY, $urandom);
		send_idle_on = (phase % 4 == 0) || (phase % 4 == 2);
		recv_idle_on = (phase % 4 == 0) || (phase % 4 == 3);
		repeat (PHASE_LEN) begin
			kind = $urandom_range(0, 99);
			last = ($urandom_range(0, 15) == 0);
			if (kind < 55) begin
				e = nudge(pt_east, -4096, 4096);
				n = nudge(pt_north, -4096, 4096);
				z = nudge(pt_depth, -2048, 16384);
			end else if (kind < 70) begin
				if ($urandom_range(0, 1)) begin
					e = $urandom;
					n = nudge(pt_north, -256, 256);
				end else begin
					n = $urandom;
					e = nudge(pt_east, -256, 256);
				end
				h2 = sq_step(longint'(e), pt_east) + sq_step(longint'(n), pt_north);
				h = longint'(floor_root(h2));
				if (h > MAG_LIMIT)
					h = MAG_LIMIT;
				z = 32'((pt_depth >= 0) ? pt_depth - h : pt_depth + h);
			end else if (kind < 80) begin
				e = $urandom;
				n = $urandom;
				z = nodata_q;
			end else if (kind < 90) begin
				e = 32'(pt_east);
				n = 32'(pt_north);
				z = 32'(pt_depth);
			end else begin
				e = nudge(pt_east, -(1 << 20), 1 << 20);
				n = nudge(pt_north, -(1 << 20), 1 << 20);
				z = nudge(pt_depth, -(1 << 20), 1 << 20);
			end
			send_sample(e, n, z, last);
		end
	endtask

	// both horizontal steps capped: the root alone overruns the range, the sum clips high
	task automatic test_depth_overflow();
		logic signed [31:0] z;
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
		z = 32'(pt_depth);
		send_sample(WORD_MIN, WORD_MIN, z, 1'b0);
		send_sample(WORD_MAX, WORD_MAX, z, 1'b1);
		send_sample(WORD_MAX, WORD_MAX, nudge(pt_depth, 0, 4096), 1'b0);
	endtask

	// ---------------------------------------------------------------- checking

	// m_* words are compared with the oldest expectation at the accepting edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_depths.size() == 0) begin
				$error("vertical_depth: expected none, actual %h", m_tdata);
				mismatch_count++;
			end else begin
				head_word = pending_depths.pop_front();
				if (m_tdata !== head_word.depth) begin
					$error("vertical_depth: expected %h, actual %h", head_word.depth, m_tdata);
					mismatch_count++;
				end
				if (m_tlast !== head_word.last) begin
					$error("last_out: expected %b, actual %b", head_word.last, m_tlast);
					mismatch_count++;
				end
			end
		end
	end

	// receiver: random stall after each accepted word, ready held otherwise
	initial begin : output_sink
		int unsigned gap;
		@(posedge arst_n);
		forever begin
			gap = recv_idle_on ? $urandom_range(0, 11) : 0;
			repeat (gap) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// watchdog: too many cycles with no word and no register access on any port
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		@(posedge arst_n);
		while (quiet_cycles < WATCHDOG) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		nodata_q = wvdt_pkg::NODATA_RESET;
		kelly_q = wvdt_pkg::KELLY_RESET;
		have_point = 1'b0;
		pt_east = 0;
		pt_north = 0;
		pt_depth = 0;
		pt_vertical = 0;
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_reset();
		test_nodata_before_first();
		test_first_sample_overflow();
		test_saturated_steps();
		test_radicand_cases();
		test_nodata_codes();
		for (int p = 0; p < 5; p++)
			test_random_survey(p);
		// last: once the sum clips high it stays there for the rest of the run
		test_depth_overflow();

		wait_idle();
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### well_vertical_depth_tracker.f
+incdir+sv
sv/wvdt_pkg.sv
sv/wvdt_ctrl.sv
sv/wvdt_dp.sv
sv/well_vertical_depth_tracker.sv
sv/wvdt_checker.sv
verif/testbench.sv
